// File: hw/rtl/csws_pkg.sv
// Package for the centered squared window sum block.
// Shared widths, reset values, state encoding and inter-module structs.
// No dependencies.
`default_nettype none

package csws_pkg;

	localparam int WIN_W           = 7;
	localparam int SUM_W           = 37;
	localparam int SEEN_W          = 7;
	localparam int SEEN_MAX        = 127;
	localparam int WIN_RESET       = 30;
	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	typedef enum logic [0:0] {
		ST_RUN,
		ST_DRAIN
	} state_t;

	// ring write / clear strobes
	typedef struct packed {
		logic wr_en;
		logic clr;
	} ring_ctl_t;

	// controller status toward the channel logic
	typedef struct packed {
		logic take;
		logic draining;
	} ctrl_stat_t;

	// one result headed for the output register
	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] sum;
		logic             last;
		logic             too_short;
	} res_t;

endpackage

`default_nettype wire

// File: hw/rtl/centered_squared_window_sum.sv
// Top level of the centered squared window sum block.
// Holds the window length register, input and output registers.
// Depends on csws_pkg, csws_ring, csws_ctrl.
//
// Usage:
//   Samples enter on in_valid/in_ready with sample and frame_end; results
//   leave on out_valid/out_ready with window_sum, last_result, too_short.
//   win_len is written over cfg_valid/cfg_ready (always ready) and
//   is expected to change only while the block is idle.
// Throughput: one sample per cycle while no drain or held result stalls
//   it. The first (W+1)/2 samples of a frame give no result; each later
//   sample gives one. A sample that ends a frame of at least W samples
//   starts a drain of (W+1)/2 further sums, one per cycle while the output
//   register is free; the input register takes one more sample meanwhile
//   and then holds off. Path: input register, then sum logic into the
//   output register.
// Stalls: a result waits in the output register; the input register still
//   takes one sample, and items that give no result keep flowing.
// Reset: window length returns to 30 and the frame state is empty. The
//   ring is cleared at once through per-entry valid bits; no clearing pass.
`default_nettype none

module centered_squared_window_sum
	import csws_pkg::*;
#(
	parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [WIN_W-1:0]       win_len,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic                   frame_end,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [SUM_W-1:0]            window_sum,
	output logic                        last_result,
	output logic                        too_short
);

	localparam int POS_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SQ_W  = 2 * SAMPLE_BITS - 1;

	logic [WIN_W-1:0]       win_q;
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   end_s1;
	logic                   out_valid_q;
	logic [SUM_W-1:0]       sum_q;
	logic                   last_q;
	logic                   short_q;
	logic                   slot_free;

	ctrl_stat_t       stat;
	res_t             res;
	ring_ctl_t        ring_ctl;
	logic [POS_W-1:0] wr_addr, rd_addr;
	logic [SQ_W-1:0]  wr_data, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WIN_W'(WIN_RESET);
		end else if (cfg_valid && cfg_ready) begin
			win_q <= win_len;
		end
	end

	// input register
	assign in_ready = !valid_s1 || stat.take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (stat.take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample;
			end_s1    <= frame_end;
		end
	end

	csws_ring #(
		.POS_W (POS_W),
		.SQ_W  (SQ_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ring_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.head    (head)
	);

	csws_ctrl #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS),
		.POS_W       (POS_W),
		.SQ_W        (SQ_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.win        (win_q),
		.item_valid (valid_s1),
		.sample_s1  (sample_s1),
		.end_s1     (end_s1),
		.slot_free  (slot_free),
		.head       (head),
		.stat       (stat),
		.res        (res),
		.ring_ctl   (ring_ctl),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr)
	);

	// output register
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			sum_q   <= res.sum;
			last_q  <= res.last;
			short_q <= res.too_short;
		end
	end

	assign out_valid   = out_valid_q;
	assign window_sum  = sum_q;
	assign last_result = last_q;
	assign too_short   = short_q;

	// a result is never loaded over one that has not been transferred
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (!out_valid_q || out_ready))
		else $error("result loaded into occupied output register");

	// no sample is consumed while the window drains
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.draining |-> !stat.take)
		else $error("sample taken during drain");

	// a short-frame result is the frame's last and carries a zero sum
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && too_short) |-> (last_result && (window_sum == '0)))
		else $error("malformed short-frame result");

	// the ring is cleared only together with a frame-ending result
	assert property (@(posedge clk) disable iff (!arst_n)
		ring_ctl.clr |-> (res.valid && res.last))
		else $error("ring cleared without final result");

endmodule

`default_nettype wire

// File: hw/rtl/csws_ring.sv
// Square ring store: MAX_WINDOW entries with per-entry valid bits.
// Prefetches the entry at the next ring position into a register.
// Depends on csws_pkg.
`default_nettype none

module csws_ring
	import csws_pkg::*;
#(
	parameter int POS_W = 6,
	parameter int SQ_W  = 31,
	parameter int DEPTH = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ring_ctl_t       ctl,
	input  wire logic [POS_W-1:0] wr_addr,
	input  wire logic [SQ_W-1:0]  wr_data,
	input  wire logic [POS_W-1:0] rd_addr,
	output logic      [SQ_W-1:0]  head
);

	logic [SQ_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [SQ_W-1:0] head_data_q;
	logic            head_vld_q;
	logic            bypass;

	assign bypass = ctl.wr_en && (wr_addr == rd_addr);

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		head_data_q <= bypass ? wr_data : mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			head_vld_q <= 1'b0;
		end else if (ctl.clr) begin
			valid_q    <= '0;
			head_vld_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			head_vld_q <= bypass || valid_q[rd_addr];
		end
	end

	// never-written entries of this frame read as zero
	assign head = head_vld_q ? head_data_q : '0;

endmodule

`default_nettype wire

// File: hw/rtl/csws_ctrl.sv
// Window controller: squares the held sample, keeps the running sum,
// ring position and sample count, and sequences the end-of-frame drain.
// Depends on csws_pkg.
`default_nettype none

module csws_ctrl
	import csws_pkg::*;
#(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16,
	parameter int POS_W       = 6,
	parameter int SQ_W        = 31
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [WIN_W-1:0]       win,
	input  wire logic                   item_valid,
	input  wire logic [SAMPLE_BITS-1:0] sample_s1,
	input  wire logic                   end_s1,
	input  wire logic                   slot_free,
	input  wire logic [SQ_W-1:0]        head,
	output ctrl_stat_t                  stat,
	output res_t                        res,
	output ring_ctl_t                   ring_ctl,
	output logic [POS_W-1:0]            wr_addr,
	output logic [SQ_W-1:0]             wr_data,
	output logic [POS_W-1:0]            rd_addr
);

	localparam int CNT_W = $clog2((MAX_WINDOW + 1) / 2 + 1);
	localparam int AW    = WIN_W + 1;

	state_t            state_q, state_d;
	logic [SUM_W-1:0]  sum_q, sum_d;
	logic [POS_W-1:0]  pos_q, pos_d, pos_adv;
	logic [SEEN_W-1:0] seen_q, seen_d, seen_inc;
	logic [CNT_W-1:0]  cnt_q, cnt_d;

	logic [WIN_W-1:0]         w_eff, h7;
	logic [WIN_W:0]           w_inc;
	logic [AW-1:0]            pos_inc;
	logic signed [2*SAMPLE_BITS-1:0] prod;
	logic [SQ_W-1:0]          sq;
	logic [SUM_W-1:0]         sq_ext, head_ext;
	logic                     short_f, prime, emit;

	always_comb begin
		if (win == '0) begin
			w_eff = WIN_W'(1);
		end else if (win > WIN_W'(MAX_WINDOW)) begin
			w_eff = WIN_W'(MAX_WINDOW);
		end else begin
			w_eff = win;
		end
	end

	assign w_inc    = {1'b0, w_eff} + (WIN_W+1)'(1);
	assign h7       = w_inc[WIN_W:1];
	assign pos_inc  = AW'(pos_q) + AW'(1);
	assign pos_adv  = (pos_inc >= AW'(w_eff)) ? '0 : pos_inc[POS_W-1:0];
	assign seen_inc = (seen_q == SEEN_W'(SEEN_MAX)) ? seen_q : seen_q + SEEN_W'(1);

	assign prod     = $signed(sample_s1) * $signed(sample_s1);
	assign sq       = prod[SQ_W-1:0];
	assign sq_ext   = SUM_W'(sq);
	assign head_ext = SUM_W'(head);

	assign short_f = end_s1 && (seen_inc < w_eff);
	assign prime   = seen_q < h7;
	assign emit    = short_f || !prime;

	always_comb begin
		state_d   = state_q;
		sum_d     = sum_q;
		pos_d     = pos_q;
		seen_d    = seen_q;
		cnt_d     = cnt_q;
		stat      = '0;
		res       = '0;
		res.sum   = sum_q;
		ring_ctl  = '0;
		wr_addr   = pos_q;
		wr_data   = sq;
		stat.draining = (state_q == ST_DRAIN);

		unique case (state_q)
			ST_RUN: begin
				if (item_valid && (!emit || slot_free)) begin
					stat.take = 1'b1;
					if (short_f) begin
						res.valid     = 1'b1;
						res.sum       = '0;
						res.last      = 1'b1;
						res.too_short = 1'b1;
						sum_d         = '0;
						pos_d         = '0;
						seen_d        = '0;
						ring_ctl.clr  = 1'b1;
					end else begin
						ring_ctl.wr_en = 1'b1;
						res.valid      = !prime;
						// priming adds only; later samples also drop the oldest square
						sum_d  = prime ? sum_q + sq_ext : sum_q - head_ext + sq_ext;
						pos_d  = pos_adv;
						seen_d = seen_inc;
						if (end_s1) begin
							state_d = ST_DRAIN;
							cnt_d   = CNT_W'(h7);
						end
					end
				end
			end
			ST_DRAIN: begin
				if (slot_free) begin
					res.valid = 1'b1;
					res.last  = (cnt_q == CNT_W'(1));
					sum_d     = sum_q - head_ext;
					pos_d     = pos_adv;
					cnt_d     = cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_d      = ST_RUN;
						sum_d        = '0;
						pos_d        = '0;
						seen_d       = '0;
						ring_ctl.clr = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	// ring prefetches the entry the next cycle will see
	assign rd_addr = pos_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			sum_q   <= '0;
			pos_q   <= '0;
			seen_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			sum_q   <= sum_d;
			pos_q   <= pos_d;
			seen_q  <= seen_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

// File: test/centered_squared_window_sum_tb.sv
// Testbench for centered_squared_window_sum: drives framed samples, predicts window sums
// with its own model of the ring and running sum, and checks every result transfer.
// Depends on csws_pkg and the centered_squared_window_sum RTL.
module centered_squared_window_sum_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import csws_pkg::*;

	localparam int MAXW  = MAX_WINDOW_DEF;
	localparam int SBITS = SAMPLE_BITS_DEF;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic [SBITS-1:0] smp;
		logic             fe;
	} sample_item_t;

	typedef struct {
		logic [SUM_W-1:0] sum;
		logic             last;
		logic             shrt;
	} window_result_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [WIN_W-1:0]     win_len       = WIN_W'(WIN_RESET);
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic [SBITS-1:0]     sample        = '0;
	logic                 frame_end     = 1'b0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	logic [SUM_W-1:0]     window_sum;
	logic                 last_result;
	logic                 too_short;

	sample_item_t   sample_fifo[$];
	window_result_t expected_sums[$];
	int             samples_queued = 0;
	int             samples_in     = 0;
	int             errors         = 0;
	bit             calm           = 1'b0;
	bit             stall_req      = 1'b0;
	bit             stall_done     = 1'b0;
	int             hold_cnt       = 0;

	// predictor state
	logic [30:0]      sq_ring[MAXW];
	logic [SUM_W-1:0] acc_sum;
	int               ring_pos;
	int               seen_cnt;
	logic [WIN_W-1:0] win_cfg = WIN_W'(WIN_RESET);

	centered_squared_window_sum #(
		.MAX_WINDOW (MAXW),
		.SAMPLE_BITS(SBITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.win_len      (win_len),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.frame_end    (frame_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.window_sum   (window_sum),
		.last_result  (last_result),
		.too_short    (too_short)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic clear_frame();
		foreach (sq_ring[i]) sq_ring[i] = '0;
		acc_sum  = '0;
		ring_pos = 0;
		seen_cnt = 0;
	endtask

	// Expected results for one accepted sample.
	task automatic predict_window_sums(input logic [SBITS-1:0] smp, input logic fe);
		int          w;
		int          h;
		int          n;
		int          p;
		int          sv;
		logic [30:0] sq;
		w  = (win_cfg == 0) ? 1 : (win_cfg > MAXW) ? MAXW : int'(win_cfg);
		h  = (w + 1) / 2;
		p  = ring_pos % MAXW;
		sv = $signed(smp);
		sq = 31'(sv * sv);
		n  = (seen_cnt < SEEN_MAX) ? seen_cnt + 1 : SEEN_MAX;
		if (fe && n < w) begin
			expected_sums.push_back('{sum: '0, last: 1'b1, shrt: 1'b1});
			clear_frame();
			return;
		end
		if (seen_cnt < h) begin
			acc_sum = acc_sum + sq;
		end else begin
			expected_sums.push_back('{sum: acc_sum, last: 1'b0, shrt: 1'b0});
			acc_sum = acc_sum - sq_ring[p] + sq;
		end
		sq_ring[p] = sq;
		ring_pos++;
		if (ring_pos >= w)
			ring_pos = 0;
		seen_cnt = n;
		if (fe) begin
			for (int k = 0; k < h; k++) begin
				p = ring_pos % MAXW;
				expected_sums.push_back('{sum: acc_sum, last: (k == h - 1), shrt: 1'b0});
				acc_sum = acc_sum - sq_ring[p];
				ring_pos++;
				if (ring_pos >= w)
					ring_pos = 0;
			end
			clear_frame();
		end
	endtask

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 11);
	endfunction

	// sample driver
	always @(posedge clk or negedge arst_n) begin : drive_samples
		sample_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_window_sums(sample, frame_end);
				samples_in++;
			end
			if (!in_valid || in_ready) begin
				if (sample_fifo.size() != 0 && !idle_now()) begin
					nxt = sample_fifo.pop_front();
					in_valid  <= 1'b1;
					sample    <= nxt.smp;
					frame_end <= nxt.fe;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver
	always @(posedge clk or negedge arst_n) begin : check_sums
		window_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cnt = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_sums.size() == 0) begin
					$display("%0t: unexpected result sum=%0d last=%0b short=%0b",
						$time, window_sum, last_result, too_short);
					errors++;
				end else begin
					want = expected_sums.pop_front();
					if ({window_sum, last_result, too_short} !==
						{want.sum, want.last, want.shrt}) begin
						$display({"%0t: mismatch expected sum=%0d last=%0b short=%0b,",
							" got sum=%0d last=%0b short=%0b"},
							$time, want.sum, want.last, want.shrt,
							window_sum, last_result, too_short);
						errors++;
					end
				end
			end
			if (stall_req && !stall_done) begin
				hold_cnt = 150;
				stall_done = 1'b1;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !idle_now();
			end
		end
	end

	task automatic push_item(input logic [SBITS-1:0] s, input logic fe);
		sample_fifo.push_back('{smp: s, fe: fe});
		samples_queued++;
	endtask

	function automatic logic [SBITS-1:0] rand_sample();
		int r;
		r = $urandom_range(99);
		if (r < 3)  return 16'h8000;
		if (r < 6)  return 16'h7fff;
		if (r < 8)  return 16'h0000;
		if (r < 10) return 16'hffff;
		return SBITS'($urandom);
	endfunction

	task automatic push_frame(input int len, input bit with_end);
		for (int i = 0; i < len; i++)
			push_item(rand_sample(), with_end && (i == len - 1));
	endtask

	// wait until every sample is in and every result out, then let the block go quiet
	task automatic settle();
		while (samples_in != samples_queued || expected_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] v);
		cfg_valid <= 1'b1;
		win_len   <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		win_cfg = v;
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int               left;
		int               len;
		int               w_eff;
		int               r;
		logic [WIN_W-1:0] w_pick;
		clear_frame();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset window of 30: short frame
		push_item(16'h8000, 1'b0);
		push_item(16'h7fff, 1'b0);
		push_item(16'h0000, 1'b1);
		settle();

		write_window(WIN_W'(1));
		push_item(16'h8000, 1'b0);
		push_item(16'h7fff, 1'b0);
		push_item(16'hffff, 1'b1);
		push_item(16'h0001, 1'b1);    // one-sample frame
		settle();

		// zero acts as one
		write_window(WIN_W'(0));
		push_item(16'h8000, 1'b0);
		push_item(16'h8000, 1'b0);
		push_item(16'h8000, 1'b1);
		settle();

		// even window, short frame then a full one
		write_window(WIN_W'(2));
		push_item(16'h7fff, 1'b1);
		push_item(16'h1234, 1'b0);
		push_item(16'hedcb, 1'b0);
		push_item(16'h8001, 1'b0);
		push_item(16'h0100, 1'b1);
		settle();

		// length change in the middle of a frame
		write_window(WIN_W'(3));
		push_item(16'h4000, 1'b0);
		push_item(16'hc000, 1'b0);
		push_item(16'h7fff, 1'b0);
		push_item(16'h8000, 1'b0);
		settle();
		write_window(WIN_W'(2));
		push_item(16'h0003, 1'b0);
		push_item(16'hfffd, 1'b0);
		push_item(16'h5555, 1'b1);
		settle();

		// largest window through an out-of-range value, frame just past a full window;
		// the receiver holds off meanwhile so the input backs up
		write_window(WIN_W'(127));
		stall_req = 1'b1;
		push_frame(66, 1'b1);
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			calm = (ph == 2);
			r = $urandom_range(99);
			if (r < 10)
				w_pick = '0;
			else if (r < 75)
				w_pick = WIN_W'($urandom_range(1, 8));
			else if (r < 95)
				w_pick = WIN_W'($urandom_range(9, 16));
			else
				w_pick = WIN_W'($urandom_range(MAXW + 1, 127));
			write_window(w_pick);
			w_eff = (w_pick == 0) ? 1 : (w_pick > MAXW) ? MAXW : int'(w_pick);
			left = 7;
			while (left > 0) begin
				if (w_eff > 16)
					len = $urandom_range(1, 20);
				else if ($urandom_range(99) < 70)
					len = $urandom_range(w_eff, 2 * w_eff + 2);
				else
					len = $urandom_range(1, w_eff);
				push_frame(len, 1'b1);
				left -= len;
			end
			// sometimes leave the frame open across the next length write
			if ($urandom_range(99) < 25)
				push_frame($urandom_range(1, w_eff), 1'b0);
			settle();
		end
		calm = 1'b0;

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: centered_squared_window_sum.f
hw/rtl/csws_pkg.sv
hw/rtl/csws_ring.sv
hw/rtl/csws_ctrl.sv
hw/rtl/centered_squared_window_sum.sv
test/centered_squared_window_sum_tb.sv
